// ===== rtl/itf_pkg.sv =====
// Shared types and constants for the integer to text formatter.
// Holds the request and character structs, ASCII codes and digit tables.
// No dependencies.
package itf_pkg;

    typedef struct packed {
        logic [31:0] magnitude;
        logic        is_negative;
        logic [4:0]  radix;
        logic [5:0]  min_digits;
        logic [5:0]  field_width;
        logic        zero_pad;
        logic        left_align;
        logic        plus_sign;
        logic        space_sign;
        logic        alt_form;
        logic        signed_conv;
        logic        upper_case;
    } t_itf_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_itf_char;

    // Restoring division steps performed by the shared unit in one cycle.
    localparam int STEPS_PER_CYCLE = 8;

    localparam logic [5:0] WIDTH_CAP = 6'd48;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    // Written high digit first so that element d holds the character of digit d.
    localparam logic [15:0][7:0] UPPER_DIGITS = "FEDCBA9876543210";
    localparam logic [15:0][7:0] LOWER_DIGITS = "fedcba9876543210";

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        digit_char = upper ? UPPER_DIGITS[d] : LOWER_DIGITS[d];
    endfunction

endpackage

// ===== rtl/integer_to_text_formatter.sv =====
// Integer to text formatter: one request in, a field of ASCII characters out.
// A request runs the shared divider over each digit in turn, then the prepare and load
// states, then emits one character per cycle; busy drops as the last character is strobed.
// Characters go out one per cycle, each for a single cycle; the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle and drops the strobe.
module integer_to_text_formatter #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  itf_pkg::t_itf_req i_req,
    output logic              o_valid,
    output itf_pkg::t_itf_char o_char
);
    import itf_pkg::*;

    localparam int QW      = ((VALUE_BITS + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE)
                             * STEPS_PER_CYCLE;
    localparam int CHUNKS  = QW / STEPS_PER_CYCLE;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int IDX_W   = $clog2(VALUE_BITS);
    localparam int LEN_W   = (CNT_W > 6) ? CNT_W : 6;
    localparam int CORE_W  = LEN_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        P_LPAD,
        P_SIGN,
        P_PFX0,
        P_PFXL,
        P_ZPAD,
        P_OCT,
        P_DIG,
        P_RPAD
    } t_phase;

    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [LEN_W-1:0]     r_left, n_left;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [LEN_W-1:0]     r_prec, n_prec;
    logic [CHUNK_W-1:0]   r_chunk, n_chunk;
    logic [QW-1:0]        r_work, n_work;
    logic [3:0]           r_rem, n_rem;
    logic [4:0]           r_radix, n_radix;
    logic [5:0]           r_width, n_width;
    logic                 r_upper, n_upper;
    logic                 r_left_al, n_left_al;
    logic                 r_zp, n_zp;
    logic                 r_has_sign, n_has_sign;
    logic [7:0]           r_sign_ch, n_sign_ch;
    logic                 r_pfx, n_pfx;
    logic [7:0]           r_pfx_ch, n_pfx_ch;
    logic                 r_oct, n_oct;
    logic [5:0]           r_pad, n_pad;
    logic [7:0]           r_present, n_present;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic [3:0]           r_rd_data;
    logic                 r_out_valid, n_out_valid;
    t_itf_char            r_out, n_out;

    logic [3:0]           r_digit_mem [VALUE_BITS];

    logic [QW-1:0]        step_work;
    logic [3:0]           step_rem;
    logic                 chunk_last;
    logic                 digit_wr;

    itf_divstep #(
        .WORK_BITS(QW)
    ) u_divstep (
        .i_work (r_work),
        .i_rem  (r_rem),
        .i_radix(r_radix),
        .o_work (step_work),
        .o_rem  (step_rem)
    );

    // Lowest present phase at or after the given one.
    function automatic logic [3:0] find_phase(input logic [7:0] mask, input logic [3:0] from);
        logic [3:0] res;
        res = 4'd0;
        for (int i = 7; i >= 0; i--) begin
            if (mask[i] && (i >= int'(from))) begin
                res = {1'b1, 3'(i)};
            end
        end
        find_phase = res;
    endfunction

    function automatic logic [LEN_W-1:0] phase_len(input t_phase p, input logic [5:0] pad,
                                                   input logic [CNT_W-1:0] n);
        logic [LEN_W-1:0] len;
        unique case (p)
            P_LPAD, P_ZPAD, P_RPAD: len = LEN_W'(pad);
            P_DIG:                  len = LEN_W'(n);
            default:                len = LEN_W'(1);
        endcase
        phase_len = len;
    endfunction

    assign busy       = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_char     = r_out;
    assign chunk_last = (r_chunk == CHUNK_W'(CHUNKS - 1));
    assign digit_wr   = (r_state == ST_DIV) && chunk_last;

    always_comb begin
        logic [63:0]       mag64;
        logic [63:0]       mask64;
        logic [4:0]        rad;
        logic [CNT_W-1:0]  cnt_inc;
        logic [LEN_W-1:0]  prec_dec;
        logic [CORE_W-1:0] core;
        logic [3:0]        found;
        logic [7:0]        ch;
        logic              last;

        n_state     = r_state;
        n_phase     = r_phase;
        n_left      = r_left;
        n_n         = r_n;
        n_prec      = r_prec;
        n_chunk     = r_chunk;
        n_work      = r_work;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_width     = r_width;
        n_upper     = r_upper;
        n_left_al   = r_left_al;
        n_zp        = r_zp;
        n_has_sign  = r_has_sign;
        n_sign_ch   = r_sign_ch;
        n_pfx       = r_pfx;
        n_pfx_ch    = r_pfx_ch;
        n_oct       = r_oct;
        n_pad       = r_pad;
        n_present   = r_present;
        n_rd_idx    = r_rd_idx;
        n_out_valid = 1'b0;
        n_out       = r_out;

        mask64   = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        mag64    = {32'd0, i_req.magnitude} & mask64;
        rad      = i_req.radix;
        cnt_inc  = r_n + CNT_W'(1);
        prec_dec = (r_prec != '0) ? r_prec - LEN_W'(1) : '0;
        core     = '0;
        found    = '0;
        ch       = CH_SPACE;
        last     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (rad < 5'd2) begin
                        rad = 5'd2;
                    end else if (rad > 5'(MAX_RADIX)) begin
                        rad = 5'(MAX_RADIX);
                    end
                    n_radix   = rad;
                    n_work    = mag64[QW-1:0];
                    n_rem     = '0;
                    n_chunk   = '0;
                    n_n       = '0;
                    n_prec    = ({1'b0, i_req.min_digits} > 7'(VALUE_BITS))
                                ? LEN_W'(VALUE_BITS) : LEN_W'(i_req.min_digits);
                    n_width   = (i_req.field_width > WIDTH_CAP) ? WIDTH_CAP
                                : i_req.field_width;
                    n_upper   = i_req.upper_case;
                    n_left_al = i_req.left_align;
                    n_zp      = i_req.zero_pad && !i_req.left_align;
                    if (i_req.is_negative && i_req.signed_conv) begin
                        n_has_sign = 1'b1;
                        n_sign_ch  = CH_MINUS;
                    end else if (i_req.space_sign) begin
                        n_has_sign = 1'b1;
                        n_sign_ch  = CH_SPACE;
                    end else if (i_req.plus_sign) begin
                        n_has_sign = 1'b1;
                        n_sign_ch  = CH_PLUS;
                    end else begin
                        n_has_sign = 1'b0;
                        n_sign_ch  = CH_SPACE;
                    end
                    n_pfx    = i_req.alt_form && ((rad == 5'd2) || (rad == 5'd16));
                    n_pfx_ch = (rad == 5'd2) ? CH_LOWER_B : CH_LOWER_X;
                    n_oct    = i_req.alt_form && (rad == 5'd8);
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                n_work  = step_work;
                n_rem   = step_rem;
                n_chunk = r_chunk + CHUNK_W'(1);
                if (chunk_last) begin
                    // A digit is complete: the remainder goes to the digit store.
                    n_chunk = '0;
                    n_rem   = '0;
                    n_n     = cnt_inc;
                    n_prec  = prec_dec;
                    if (!((step_work != '0) || (prec_dec != '0))
                        || (cnt_inc >= CNT_W'(VALUE_BITS))) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                core = CORE_W'(r_n) + CORE_W'(r_has_sign) + CORE_W'(r_oct)
                     + ((r_pfx && !r_zp) ? CORE_W'(2) : CORE_W'(0));
                n_pad = (CORE_W'(r_width) > core) ? 6'(CORE_W'(r_width) - core) : 6'd0;
                n_present[P_LPAD] = !r_left_al && !r_zp && (n_pad != '0);
                n_present[P_SIGN] = r_has_sign;
                n_present[P_PFX0] = r_pfx;
                n_present[P_PFXL] = r_pfx;
                n_present[P_ZPAD] = r_zp && (n_pad != '0);
                n_present[P_OCT]  = r_oct;
                n_present[P_DIG]  = 1'b1;
                n_present[P_RPAD] = r_left_al && (n_pad != '0);
                n_rd_idx = IDX_W'(r_n - CNT_W'(1));
                n_state  = ST_LOAD;
            end
            ST_LOAD: begin
                found   = find_phase(r_present, 4'd0);
                n_phase = t_phase'(found[2:0]);
                n_left  = phase_len(t_phase'(found[2:0]), r_pad, r_n);
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                unique case (r_phase)
                    P_LPAD, P_RPAD:        ch = CH_SPACE;
                    P_SIGN:                ch = r_sign_ch;
                    P_PFXL:                ch = r_pfx_ch;
                    P_PFX0, P_ZPAD, P_OCT: ch = CH_ZERO;
                    P_DIG:                 ch = digit_char(r_rd_data, r_upper);
                    default:               ch = CH_SPACE;
                endcase
                if (r_phase == P_DIG) begin
                    n_rd_idx = r_rd_idx - IDX_W'(1);
                end
                if (r_left == LEN_W'(1)) begin
                    found = find_phase(r_present, {1'b0, r_phase} + 4'd1);
                    if (found[3]) begin
                        n_phase = t_phase'(found[2:0]);
                        n_left  = phase_len(t_phase'(found[2:0]), r_pad, r_n);
                    end else begin
                        last    = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_left = r_left - LEN_W'(1);
                end
                n_out_valid     = 1'b1;
                n_out.out_char  = ch;
                n_out.last_char = last;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_phase    <= n_phase;
        r_left     <= n_left;
        r_n        <= n_n;
        r_prec     <= n_prec;
        r_chunk    <= n_chunk;
        r_work     <= n_work;
        r_rem      <= n_rem;
        r_radix    <= n_radix;
        r_width    <= n_width;
        r_upper    <= n_upper;
        r_left_al  <= n_left_al;
        r_zp       <= n_zp;
        r_has_sign <= n_has_sign;
        r_sign_ch  <= n_sign_ch;
        r_pfx      <= n_pfx;
        r_pfx_ch   <= n_pfx_ch;
        r_oct      <= n_oct;
        r_pad      <= n_pad;
        r_present  <= n_present;
        r_rd_idx   <= n_rd_idx;
        r_out      <= n_out;
    end

    // Digit store: written least significant digit first, read back in reverse.
    // The read address is the next index, so the read data tracks r_rd_idx.
    always_ff @(posedge i_clk) begin
        if (digit_wr) begin
            r_digit_mem[r_n[IDX_W-1:0]] <= step_rem;
        end
        r_rd_data <= r_digit_mem[n_rd_idx];
    end

    a_last_ends_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char.last_char) |=> !o_valid)
        else $error("character strobe continued past the final character");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_digit_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_n < CNT_W'(VALUE_BITS)))
        else $error("digit count ran past the digit store depth");

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_EMIT))
        else $error("character strobe outside the emit sequence");

endmodule

// ===== rtl/itf_divstep.sv =====
// Shared divider unit: several restoring division steps by a small radix.
// Shifts quotient bits into the low end of the work word as dividend bits leave the top.
// Depends on itf_pkg.
module itf_divstep #(
    parameter int WORK_BITS = 32
) (
    input  logic [WORK_BITS-1:0] i_work,
    input  logic [3:0]           i_rem,
    input  logic [4:0]           i_radix,
    output logic [WORK_BITS-1:0] o_work,
    output logic [3:0]           o_rem
);
    import itf_pkg::*;

    always_comb begin
        logic [WORK_BITS-1:0] w;
        logic [4:0]           t;
        w = i_work;
        t = {1'b0, i_rem};
        for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
            // The partial remainder stays below the radix, so it fits in four bits.
            t = {t[3:0], w[WORK_BITS-1]};
            if (t >= i_radix) begin
                t = t - i_radix;
                w = {w[WORK_BITS-2:0], 1'b1};
            end else begin
                w = {w[WORK_BITS-2:0], 1'b0};
            end
        end
        o_work = w;
        o_rem  = t[3:0];
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for integer_to_text_formatter: directed and random requests.
// Expected characters come from an in-bench field layout predictor.
// Depends on itf_pkg and the integer_to_text_formatter RTL.
module testbench;
    import itf_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // Flag masks for building requests.
    localparam logic [7:0] F_NEG    = 8'h80;
    localparam logic [7:0] F_ZPAD   = 8'h40;
    localparam logic [7:0] F_LEFT   = 8'h20;
    localparam logic [7:0] F_PLUS   = 8'h10;
    localparam logic [7:0] F_SPACE  = 8'h08;
    localparam logic [7:0] F_ALT    = 8'h04;
    localparam logic [7:0] F_SIGNED = 8'h02;
    localparam logic [7:0] F_UPPER  = 8'h01;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_itf_req  req_drv;
    logic      o_valid;
    t_itf_char o_char;

    t_itf_char expected_chars[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        bursts_on = 1'b1;

    integer_to_text_formatter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req_drv),
        .o_valid (o_valid),
        .o_char  (o_char)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_itf_req make_request(input logic [31:0] mag, input logic [4:0] radix,
                                              input logic [5:0] prec, input logic [5:0] width,
                                              input logic [7:0] flags);
        t_itf_req r;
        r.magnitude   = mag;
        r.is_negative = (flags & F_NEG) != 0;
        r.radix       = radix;
        r.min_digits  = prec;
        r.field_width = width;
        r.zero_pad    = (flags & F_ZPAD) != 0;
        r.left_align  = (flags & F_LEFT) != 0;
        r.plus_sign   = (flags & F_PLUS) != 0;
        r.space_sign  = (flags & F_SPACE) != 0;
        r.alt_form    = (flags & F_ALT) != 0;
        r.signed_conv = (flags & F_SIGNED) != 0;
        r.upper_case  = (flags & F_UPPER) != 0;
        return r;
    endfunction

    function automatic t_itf_req random_request();
        int          bits;
        int          sel;
        logic [31:0] mag;
        logic [4:0]  radix;
        logic [5:0]  prec;
        logic [5:0]  width;
        bits = $urandom_range(0, 32);
        mag  = (bits == 0) ? 32'd0 : ($urandom >> (32 - bits));
        if ($urandom_range(0, 15) == 0) mag = '1;
        sel = $urandom_range(0, 9);
        if (sel < 2) radix = 5'($urandom_range(0, 31));
        else if (sel < 4) radix = 5'($urandom_range(2, 16));
        else begin
            case (sel % 4)
                0: radix = 5'd2;
                1: radix = 5'd8;
                2: radix = 5'd10;
                default: radix = 5'd16;
            endcase
        end
        // Mostly short fields; now and then the full range of both counts.
        prec  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 10));
        width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 16));
        return make_request(mag, radix, prec, width, 8'($urandom));
    endfunction

    // Lays out the field: padding, sign, prefix, zeros, octal zero, digits, trailing spaces.
    task automatic predict_field(input t_itf_req r);
        logic [3:0]  digits [32];
        logic [7:0]  text[$];
        logic [31:0] quot;
        int unsigned base, prec, width, n, core, pad, i;
        logic        left, zp, octal0;
        logic [7:0]  sign_ch, prefix_ch, dval, ch;
        t_itf_char   c;
        base = 32'(r.radix);
        if (base < 2) base = 2;
        if (base > 16) base = 16;
        prec = 32'(r.min_digits);
        if (prec > 32) prec = 32;
        width = 32'(r.field_width);
        if (width > 48) width = 48;
        left = r.left_align;
        zp   = r.zero_pad & ~left;

        quot = r.magnitude;
        n = 0;
        do begin
            digits[n] = 4'(quot % base);
            quot = 32'(quot / base);
            n++;
            if (prec != 0) prec--;
        end while ((quot != 0 || prec != 0) && n < 32);

        sign_ch = 8'h00;
        if (r.is_negative && r.signed_conv) sign_ch = "-";
        else if (r.space_sign) sign_ch = " ";
        else if (r.plus_sign) sign_ch = "+";

        prefix_ch = 8'h00;
        octal0 = 1'b0;
        if (r.alt_form) begin
            if (base == 2) prefix_ch = "b";
            else if (base == 16) prefix_ch = "x";
            else if (base == 8) octal0 = 1'b1;
        end

        core = n + (sign_ch != 0) + octal0 + ((prefix_ch != 0 && !zp) ? 2 : 0);
        pad  = (width > core) ? width - core : 0;

        if (!left && !zp) repeat (pad) text.push_back(" ");
        if (sign_ch != 0) text.push_back(sign_ch);
        if (prefix_ch != 0) begin
            text.push_back("0");
            text.push_back(prefix_ch);
        end
        if (zp) repeat (pad) text.push_back("0");
        if (octal0) text.push_back("0");
        for (i = n; i > 0; i--) begin
            dval = {4'd0, digits[i-1]};
            if (dval < 10) ch = 8'h30 + dval;
            else ch = (r.upper_case ? 8'h41 : 8'h61) + dval - 8'd10;
            text.push_back(ch);
        end
        if (left) repeat (pad) text.push_back(" ");

        foreach (text[j]) begin
            c.out_char  = text[j];
            c.last_char = (j == text.size() - 1);
            expected_chars.push_back(c);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%s", what);
    endtask

    // Start stays high across back-to-back requests; it drops only for a gap or a drain.
    task automatic send_request(input t_itf_req r);
        if (bursts_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start   <= 1'b1;
        req_drv <= r;
        do @(posedge i_clk); while (busy);
        predict_field(r);
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_request(make_request(32'd0, 5'd10, 6'd0, 6'd0, 8'h00));
        send_request(make_request(32'd0, 5'd10, 6'd1, 6'd0, F_PLUS));
        send_request(make_request(32'hFFFFFFFF, 5'd2, 6'd0, 6'd0, 8'h00));
        send_request(make_request(32'hFFFFFFFF, 5'd16, 6'd0, 6'd0, F_ALT | F_UPPER));
        // Radix below two and above sixteen.
        send_request(make_request(32'd5, 5'd0, 6'd0, 6'd0, F_ALT));
        send_request(make_request(32'd5, 5'd1, 6'd0, 6'd0, 8'h00));
        send_request(make_request(32'hABCD, 5'd31, 6'd0, 6'd0, F_ALT));
        send_request(make_request(32'hABCD, 5'd17, 6'd0, 6'd0, F_UPPER));
        // Octal prefix on zero and on a value whose digits start with zero.
        send_request(make_request(32'd0, 5'd8, 6'd0, 6'd0, F_ALT));
        send_request(make_request(32'd8, 5'd8, 6'd3, 6'd6, F_ALT | F_ZPAD));
        // Saturated precision and width.
        send_request(make_request(32'd7, 5'd10, 6'd63, 6'd0, 8'h00));
        send_request(make_request(32'd1, 5'd10, 6'd0, 6'd63, F_SPACE));
        send_request(make_request(32'hAB, 5'd16, 6'd0, 6'd10, F_ZPAD | F_ALT));
        // Left justify overrides zero padding.
        send_request(make_request(32'd5, 5'd10, 6'd0, 6'd8, F_LEFT | F_ZPAD | F_NEG | F_SIGNED));
        // Negative mark alone gives no minus.
        send_request(make_request(32'd5, 5'd10, 6'd0, 6'd0, F_NEG | F_PLUS));
        send_request(make_request(32'd5, 5'd10, 6'd0, 6'd0, F_SPACE | F_PLUS));
        send_request(make_request(32'd5, 5'd10, 6'd0, 6'd0, F_NEG | F_SIGNED | F_SPACE | F_PLUS));
        send_request(make_request(32'd42, 5'd10, 6'd0, 6'd6, F_NEG | F_SIGNED | F_ZPAD));
        send_request(make_request(32'd5, 5'd2, 6'd0, 6'd12, F_ALT));
        // Prefix letter stays lower case with upper case digits.
        send_request(make_request(32'hDEAD, 5'd16, 6'd0, 6'd0, F_ALT | F_UPPER | F_LEFT));
        // Longest field: full width of zeros plus an outside prefix.
        send_request(make_request(32'd0, 5'd16, 6'd0, 6'd48, F_ZPAD | F_ALT));
        send_request(make_request(32'hFFFFFFFF, 5'd2, 6'd32, 6'd63,
                                  F_ZPAD | F_ALT | F_NEG | F_SIGNED));
        send_request(make_request(32'hFFFFFFFF, 5'd10, 6'd0, 6'd20, F_PLUS | F_LEFT));
        send_request(make_request(32'hFFFFFFFF, 5'd3, 6'd0, 6'd0, F_SIGNED));
        wait_for_drain();
    endtask

    task automatic test_random_with_gaps();
        bursts_on = 1'b1;
        repeat (320) send_request(random_request());
        wait_for_drain();
    endtask

    task automatic test_random_back_to_back();
        bursts_on = 1'b0;
        repeat (130) send_request(random_request());
        wait_for_drain();
    endtask

    // Result checker: every strobed character is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_chars
        t_itf_char want;
        if (i_rst_n && o_valid) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          o_char.out_char, o_char.last_char));
            end else begin
                want = expected_chars.pop_front();
                if (o_char.out_char !== want.out_char || o_char.last_char !== want.last_char) begin
                    report_mismatch($sformatf(
                        "character mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                        want.out_char, want.last_char, o_char.out_char, o_char.last_char));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        req_drv <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_with_gaps();
        test_random_back_to_back();

        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        end
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
